@@ sv/gsc_pkg.sv @@
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, codes and helpers shared by the gyro step counter modules.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int RATE_W     = 16;
    localparam int WEIGHT_W   = 8;
    localparam int WINDOW_W   = 8;
    localparam int COUNT_W    = 16;
    localparam int AXIS_W     = 2;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLES_PER_AVERAGE_DEF = 4;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VARIATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VARIATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WINDOW = 2'd2;

    // Reset values of the configuration registers
    localparam logic [RATE_W-1:0]   MIN_VARIATION_RST = 16'd0;
    localparam logic [RATE_W-1:0]   MAX_VARIATION_RST = 16'hFFFF;
    localparam logic [WINDOW_W-1:0] ACTIVE_WINDOW_RST = 8'd10;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } in_item_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] avg_x;
        logic signed [RATE_W-1:0] avg_y;
        logic signed [RATE_W-1:0] avg_z;
        logic [AXIS_W-1:0]        active_axis;
        logic                     step_seen;
        logic [COUNT_W-1:0]       step_total;
    } out_item_t;

    // Stage strobes from the top level to each lane
    typedef struct packed {
        logic acc;      // sample taken, average not complete
        logic close;    // sample taken, average complete
        logic div_en;   // divide stage loads
        logic upd_en;   // update stage loads
    } lane_ctl_t;

    // Per-axis state seen by the merge stage
    typedef struct packed {
        logic signed [RATE_W-1:0] curr;
        logic signed [RATE_W-1:0] prev;
        logic signed [RATE_W-1:0] high;
        logic signed [RATE_W-1:0] low;
        logic [RATE_W-1:0]        chg;
    } lane_res_t;

    // Axis code of the strictly largest of three values, AXIS_NONE on a tie
    function automatic logic [AXIS_W-1:0] strict_max3(
        input logic [RATE_W-1:0] a,
        input logic [RATE_W-1:0] b,
        input logic [RATE_W-1:0] c
    );
        logic [AXIS_W-1:0] res;
        if (a > b && a > c)
        begin
            res = AXIS_X;
        end
        else if (b > a && b > c)
        begin
            res = AXIS_Y;
        end
        else if (c > a && c > b)
        begin
            res = AXIS_Z;
        end
        else
        begin
            res = AXIS_NONE;
        end
        return res;
    endfunction

endpackage

@@ sv/gsc_lane.sv @@
// ----------------------------------------------------------------------------
// gsc_lane
// One axis: sample accumulator, constant divider, variation check and peaks.
// ----------------------------------------------------------------------------
module gsc_lane #(
    parameter int SAMPLES_PER_AVERAGE = gsc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gsc_pkg::lane_ctl_t                ctl,
    input  logic signed [gsc_pkg::RATE_W-1:0] rate,
    input  logic [gsc_pkg::RATE_W-1:0]        min_variation,
    input  logic [gsc_pkg::RATE_W-1:0]        max_variation,
    output gsc_pkg::lane_res_t                res
);

    localparam int RW        = gsc_pkg::RATE_W;
    localparam int LOG_N     = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SUM_W     = RW + LOG_N;
    localparam int DIV_SHIFT = SUM_W + LOG_N;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1)
        / 64'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_full_reg;
    logic signed [RW-1:0]    avg_reg;
    logic signed [RW-1:0]    curr_reg;
    logic signed [RW-1:0]    prev_reg;
    logic signed [RW-1:0]    high_reg;
    logic signed [RW-1:0]    low_reg;
    logic [RW-1:0]           chg_reg;

    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        abs_sum;
    logic [PROD_W-1:0]       prod;
    logic [RW:0]             quot;
    logic [RW:0]             quot_neg;
    logic signed [RW-1:0]    avg_next;
    logic [RW:0]             diff;
    logic [RW:0]             diff_neg;
    logic [RW-1:0]           chg_abs;
    logic                    chg_ok;
    logic signed [RW-1:0]    curr_next;

    assign sum_next = sum_reg + SUM_W'(rate);

    // Accumulate the window; hand the full sum to the divider on its last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.close)
        begin
            sum_reg <= '0;
        end
        else if (ctl.acc)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.close)
        begin
            sum_full_reg <= sum_next;
        end
    end

    // Divide by the window length: reciprocal multiply on the magnitude,
    // then restore the sign so the quotient truncates toward zero
    always_comb
    begin
        abs_sum  = sum_full_reg[SUM_W-1] ? SUM_W'(-sum_full_reg) : SUM_W'(sum_full_reg);
        prod     = PROD_W'(abs_sum) * PROD_W'(RECIP);
        quot     = prod[DIV_SHIFT +: RW+1];
        quot_neg = ~quot + 1'b1;
        avg_next = sum_full_reg[SUM_W-1] ? quot_neg[RW-1:0] : quot[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_en)
        begin
            avg_reg <= avg_next;
        end
    end

    // Variation check against the current average, full 16-bit magnitude
    always_comb
    begin
        diff      = {avg_reg[RW-1], avg_reg} - {curr_reg[RW-1], curr_reg};
        diff_neg  = ~diff + 1'b1;
        chg_abs   = diff[RW] ? diff_neg[RW-1:0] : diff[RW-1:0];
        chg_ok    = (chg_abs >= min_variation) && (chg_abs <= max_variation);
        curr_next = chg_ok ? avg_reg : curr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curr_reg <= '0;
            prev_reg <= '0;
            high_reg <= '0;
            low_reg  <= '0;
            chg_reg  <= '0;
        end
        else if (ctl.upd_en)
        begin
            prev_reg <= curr_reg;
            curr_reg <= curr_next;
            chg_reg  <= chg_ok ? chg_abs : '0;
            if (curr_next > high_reg)
            begin
                high_reg <= curr_next;
            end
            if (curr_next < low_reg)
            begin
                low_reg <= curr_next;
            end
        end
    end

    assign res.curr = curr_reg;
    assign res.prev = prev_reg;
    assign res.high = high_reg;
    assign res.low  = low_reg;
    assign res.chg  = chg_reg;

    a_peaks_bound_curr: assert property (
        @(posedge clk) disable iff (!rst_n)
        (high_reg >= curr_reg) && (low_reg <= curr_reg)
    ) else $error("lane peaks do not bound the current average");

    a_peaks_straddle_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        !high_reg[RW-1] && (low_reg[RW-1] || low_reg == '0)
    ) else $error("lane peaks left their zero start");

endmodule

@@ sv/gsc_merge.sv @@
// ----------------------------------------------------------------------------
// gsc_merge
// Combines the three lanes: activity weights, axis election, step detection
// and the result register.
// ----------------------------------------------------------------------------
module gsc_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  gsc_pkg::lane_res_t                  lane_res [gsc_pkg::NUM_AXES],
    input  logic [gsc_pkg::WINDOW_W-1:0]        active_window,
    input  logic                                out_stall,
    output logic                                out_valid,
    output gsc_pkg::out_item_t                  out_data
);

    localparam int RW = gsc_pkg::RATE_W;
    localparam int WW = gsc_pkg::WEIGHT_W;
    localparam int NA = gsc_pkg::NUM_AXES;

    logic [gsc_pkg::WINDOW_W-1:0] window_reg;
    logic [WW-1:0]                weight_reg [NA];
    logic [gsc_pkg::AXIS_W-1:0]   elect_reg;
    logic [gsc_pkg::COUNT_W-1:0]  count_reg;
    logic                         out_valid_reg;
    gsc_pkg::out_item_t           out_data_reg;

    logic [gsc_pkg::WINDOW_W-1:0] window_inc;
    logic                         elect_fire;
    logic [gsc_pkg::WINDOW_W-1:0] window_next;
    logic [WW-1:0]                weight_base [NA];
    logic [WW-1:0]                weight_next [NA];
    logic [gsc_pkg::AXIS_W-1:0]   pick;
    logic [gsc_pkg::AXIS_W-1:0]   elect_next;
    gsc_pkg::lane_res_t           sel;
    logic signed [RW:0]           pk_sum;
    logic [RW:0]                  pk_adj;
    logic signed [RW-1:0]         mid;
    logic                         step;
    logic [gsc_pkg::COUNT_W-1:0]  count_next;

    always_comb
    begin
        window_inc  = window_reg + 1'b1;
        elect_fire  = (window_inc >= active_window);
        window_next = elect_fire ? '0 : window_inc;

        elect_next = elect_fire
            ? gsc_pkg::strict_max3(RW'(weight_reg[0]), RW'(weight_reg[1]), RW'(weight_reg[2]))
            : elect_reg;

        // Election clears the weights before this update's change is scored
        pick = gsc_pkg::strict_max3(lane_res[0].chg, lane_res[1].chg, lane_res[2].chg);
        for (int i = 0; i < NA; i++)
        begin
            weight_base[i] = elect_fire ? '0 : weight_reg[i];
            weight_next[i] = weight_base[i];
            if (pick == gsc_pkg::AXIS_W'(i + 1) && weight_base[i] != '1)
            begin
                weight_next[i] = weight_base[i] + 1'b1;
            end
        end

        case (elect_next)
            gsc_pkg::AXIS_X: sel = lane_res[0];
            gsc_pkg::AXIS_Y: sel = lane_res[1];
            gsc_pkg::AXIS_Z: sel = lane_res[2];
            default:         sel = '0;
        endcase

        // Midpoint of the peaks, truncated toward zero
        pk_sum = {sel.high[RW-1], sel.high} + {sel.low[RW-1], sel.low};
        pk_adj = pk_sum + {{RW{1'b0}}, pk_sum[RW]};
        mid    = pk_adj[RW:1];

        step = (elect_next != gsc_pkg::AXIS_NONE)
            && (((sel.prev < mid) && (sel.curr > mid))
             || ((sel.prev > mid) && (sel.curr < mid)));
        count_next = count_reg + gsc_pkg::COUNT_W'(step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            elect_reg  <= gsc_pkg::AXIS_NONE;
            count_reg  <= '0;
            for (int i = 0; i < NA; i++)
            begin
                weight_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            window_reg <= window_next;
            elect_reg  <= elect_next;
            count_reg  <= count_next;
            for (int i = 0; i < NA; i++)
            begin
                weight_reg[i] <= weight_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_data_reg.avg_x       <= lane_res[0].curr;
            out_data_reg.avg_y       <= lane_res[1].curr;
            out_data_reg.avg_z       <= lane_res[2].curr;
            out_data_reg.active_axis <= elect_next;
            out_data_reg.step_seen   <= step;
            out_data_reg.step_total  <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // At most one weight point per update since the last election
    a_weights_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (10'(weight_reg[0]) + 10'(weight_reg[1]) + 10'(weight_reg[2]))
            <= (10'(window_reg) + 10'd1)
    ) else $error("activity weights exceed updates in window");

endmodule

@@ sv/gyro_step_counter.sv @@
// ----------------------------------------------------------------------------
// gyro_step_counter
// Pedometer on raw three-axis gyro samples: per-axis averaging lanes feed a
// merge stage that elects the most active axis and counts midpoint crossings.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_stall    | one gyro sample (in_item_t)
//  out     | output    | out_valid / out_stall  | one update (out_item_t)
//  cfg     | input     | cfg_wr_en              | cfg_index, cfg_data
//
//  One sample per cycle unless stalled. Every SAMPLES_PER_AVERAGE samples
//  make one result, which goes from the closing sample through the sum register,
//  reciprocal divider, variation/peak update, merge and result register.
//  Reset clears all but staged data; no clearing pass, first beat next cycle.
//  out_stall backs up through per-stage valid bits; in_stall rises only on
//  a sample that closes an average while the divider stage cannot load.
// ----------------------------------------------------------------------------
module gyro_step_counter #(
    parameter int SAMPLES_PER_AVERAGE = gsc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  gsc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output gsc_pkg::out_item_t                 out_data,
    input  logic                               cfg_wr_en,
    input  logic [gsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NA    = gsc_pkg::NUM_AXES;
    localparam int IDX_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_AVERAGE - 1);

    logic [gsc_pkg::RATE_W-1:0]   min_var_reg;
    logic [gsc_pkg::RATE_W-1:0]   max_var_reg;
    logic [gsc_pkg::WINDOW_W-1:0] window_len_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;

    logic                         last;
    logic                         take;
    logic                         fire2;
    logic                         fire3;
    logic                         fire4;
    logic                         rdy1;
    logic                         rdy2;
    logic                         rdy3;
    gsc_pkg::lane_ctl_t           ctl;
    gsc_pkg::lane_res_t           lane_res [NA];
    logic signed [gsc_pkg::RATE_W-1:0] lane_rate [NA];

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_var_reg    <= gsc_pkg::MIN_VARIATION_RST;
            max_var_reg    <= gsc_pkg::MAX_VARIATION_RST;
            window_len_reg <= gsc_pkg::ACTIVE_WINDOW_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gsc_pkg::REG_MIN_VARIATION: min_var_reg    <= cfg_data;
                gsc_pkg::REG_MAX_VARIATION: max_var_reg    <= cfg_data;
                gsc_pkg::REG_ACTIVE_WINDOW: window_len_reg <= cfg_data[gsc_pkg::WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: each stage loads when empty or when it drains
    always_comb
    begin
        fire4 = v3_reg && (!out_valid || !out_stall);
        rdy3  = !v3_reg || fire4;
        fire3 = v2_reg && rdy3;
        rdy2  = !v2_reg || fire3;
        fire2 = v1_reg && rdy2;
        rdy1  = !v1_reg || fire2;

        last     = (idx_reg == LAST_IDX);
        in_stall = last && !rdy1;
        take     = in_valid && !in_stall;

        ctl.acc    = take && !last;
        ctl.close  = take && last;
        ctl.div_en = fire2;
        ctl.upd_en = fire3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                idx_reg <= last ? '0 : idx_reg + 1'b1;
            end
            if (ctl.close)
            begin
                v1_reg <= 1'b1;
            end
            else if (fire2)
            begin
                v1_reg <= 1'b0;
            end
            if (fire2)
            begin
                v2_reg <= 1'b1;
            end
            else if (fire3)
            begin
                v2_reg <= 1'b0;
            end
            if (fire3)
            begin
                v3_reg <= 1'b1;
            end
            else if (fire4)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    assign lane_rate[0] = in_data.rate_x;
    assign lane_rate[1] = in_data.rate_y;
    assign lane_rate[2] = in_data.rate_z;

    for (genvar g = 0; g < NA; g++)
    begin : g_lane
        gsc_lane #(
            .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
        ) u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .rate          (lane_rate[g]),
            .min_variation (min_var_reg),
            .max_variation (max_var_reg),
            .res           (lane_res[g])
        );
    end

    gsc_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (fire4),
        .lane_res      (lane_res),
        .active_window (window_len_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );

    a_stall_only_on_close: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (idx_reg == LAST_IDX)
    ) else $error("input stalled on a sample that does not close an average");

    a_step_needs_axis: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.step_seen) |-> (out_data.active_axis != gsc_pkg::AXIS_NONE)
    ) else $error("step reported with no elected axis");

    a_result_needs_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg)
    ) else $error("result appeared without a pending update");

endmodule
